>>> src/pdc_pkg.sv
`timescale 1ns / 1ps
package pdc_pkg;
  localparam int NUM_WORDS_DEF = 4;
  localparam int FW = 256;
  localparam logic [FW-1:0] PRIME_P =
    256'hFFFFFFFF00000001000000000000000000000000FFFFFFFFFFFFFFFFFFFFFFFF;
  localparam logic [FW-1:0] COEF_A =
    256'hFFFFFFFF00000001000000000000000000000000FFFFFFFFFFFFFFFFFFFFFFFC;
  localparam logic [FW-1:0] COEF_B =
    256'h5AC635D8AA3A93E7B3EBBD55769886BC651D06B0CC53B0F63BCE3C3E27D2604B;
  localparam logic [FW-1:0] ROOT_EXP =
    256'h3FFFFFFFC0000000400000000000000000000000400000000000000000000000;

  typedef enum logic [3:0] {
    ST_COLLECT, ST_REDUCE, ST_MUL_XX, ST_MUL_TX, ST_MUL_AX, ST_ADD_U, ST_ADD_B,
    ST_EXP_SQ, ST_EXP_MB, ST_CHECK, ST_FIX, ST_EMIT
  } state_t;

  // Operand selection codes for the multiplier.
  typedef enum logic [2:0] {
    OP_XX, OP_TX, OP_AX, OP_ACC_ACC, OP_ACC_BASE, OP_CHECK
  } mop_t;

  typedef struct packed {
    logic load_word;
    logic reduce;
    logic mul_start;
    mop_t mul_op;
    logic add_u;
    logic add_b;
    logic init_acc;
    logic fix_y;
    logic shift_out;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic root_ok;
  } sts_t;
endpackage

>>> src/pdc_datapath.sv
`timescale 1ns / 1ps
module pdc_datapath
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [63:0] x_word,
  output sts_t        sts,
  output logic [63:0] y_top
);
  logic [FW-1:0] x_val, t_val, u_val, acc, y_val;
  logic [FW-1:0] ma, mb, prod;
  logic [8:0]    bit_cnt;
  logic          busy;
  logic          sq_match;
  logic [FW:0]   dbl, dbl_s, ad, ad_s, sm, sm_s;
  logic [FW-1:0] dbl_r, nxt, sm_r;

  // Double-and-add multiply: one bit of mb per cycle, most significant bit first.
  assign dbl   = {prod, 1'b0};
  assign dbl_s = dbl - {1'b0, PRIME_P};
  assign dbl_r = dbl_s[FW] ? dbl[FW-1:0] : dbl_s[FW-1:0];
  assign ad    = {1'b0, dbl_r} + {1'b0, ma};
  assign ad_s  = ad - {1'b0, PRIME_P};
  assign nxt   = mb[FW-1] ? (ad_s[FW] ? ad[FW-1:0] : ad_s[FW-1:0]) : dbl_r;

  // Shared modular adder for t + u and t + b.
  assign sm   = {1'b0, t_val} + {1'b0, (cmd.add_b ? COEF_B : u_val)};
  assign sm_s = sm - {1'b0, PRIME_P};
  assign sm_r = sm_s[FW] ? sm[FW-1:0] : sm_s[FW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (cmd.mul_start) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
      prod    <= '0;
      unique case (cmd.mul_op)
        OP_XX:       begin ma <= x_val; mb <= x_val; end
        OP_TX:       begin ma <= t_val; mb <= x_val; end
        OP_AX:       begin ma <= COEF_A; mb <= x_val; end
        OP_ACC_ACC, OP_CHECK: begin ma <= acc; mb <= acc; end
        default:     begin ma <= acc;   mb <= u_val; end
      endcase
    end else if (busy) begin
      prod    <= nxt;
      mb      <= {mb[FW-2:0], 1'b0};
      bit_cnt <= bit_cnt + 9'd1;
      if (bit_cnt == 9'd255) busy <= 1'b0;
    end
  end
  assign sts.mul_done = busy && (bit_cnt == 9'd255);

  always_ff @(posedge clk) begin
    if (cmd.load_word) x_val <= {x_val[FW-65:0], x_word};
    if (cmd.reduce && !(x_val < PRIME_P)) x_val <= x_val - PRIME_P;
    if (sts.mul_done) begin
      unique case (cmd.mul_op)
        OP_XX, OP_TX: t_val <= nxt;
        OP_AX:        u_val <= nxt;
        OP_CHECK:     sq_match <= (nxt == u_val);
        default:      acc   <= nxt;
      endcase
    end
    if (cmd.add_u || cmd.add_b) t_val <= sm_r;
    // Park the final t (sum with b) in u_val as the exponent base.
    if (cmd.init_acc) begin
      acc   <= {{(FW-1){1'b0}}, 1'b1};
      u_val <= sm_r;
    end
    if (cmd.fix_y) y_val <= (acc[0] ? PRIME_P - acc : acc);
    if (cmd.shift_out) y_val <= {y_val[FW-65:0], 64'd0};
  end

  // Square-check: latched when the check multiply finishes; acc keeps the root.
  assign sts.root_ok = sq_match;
  assign y_top = y_val[FW-1 -: 64];
endmodule

>>> src/pdc_control.sv
`timescale 1ns / 1ps
module pdc_control
  import pdc_pkg::*;
#(
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output logic last_word,
  output logic status,
  output logic y_zero,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam int CW = $clog2(NUM_WORDS);
  state_t state, state_next;
  logic [CW-1:0] word_count;
  logic [7:0] ebit;
  logic mul_run, fail;
  logic [FW-1:0] root_with_acc;
  logic in_acc, out_acc;

  assign in_acc  = in_valid && (state == ST_COLLECT);
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_COLLECT);
  assign out_valid = (state == ST_EMIT);
  assign last_word = (word_count == CW'(NUM_WORDS - 1));
  assign status = fail;
  assign y_zero = fail;
  assign root_with_acc = ROOT_EXP;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (in_acc && word_count == CW'(NUM_WORDS - 1)) state_next = ST_REDUCE;
      ST_REDUCE:  state_next = ST_MUL_XX;
      ST_MUL_XX:  if (sts.mul_done) state_next = ST_MUL_TX;
      ST_MUL_TX:  if (sts.mul_done) state_next = ST_MUL_AX;
      ST_MUL_AX:  if (sts.mul_done) state_next = ST_ADD_U;
      ST_ADD_U:   state_next = ST_ADD_B;
      ST_ADD_B:   state_next = ST_EXP_SQ;
      ST_EXP_SQ:
        if (sts.mul_done) state_next = root_with_acc[ebit] ? ST_EXP_MB :
                                       (ebit == 8'd0 ? ST_CHECK : ST_EXP_SQ);
      ST_EXP_MB:  if (sts.mul_done) state_next = (ebit == 8'd0) ? ST_CHECK : ST_EXP_SQ;
      ST_CHECK:   if (sts.mul_done) state_next = ST_FIX;
      ST_FIX:     state_next = ST_EMIT;
      ST_EMIT:    if (out_acc && word_count == CW'(NUM_WORDS - 1)) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load_word = in_acc;
    cmd.reduce    = (state == ST_REDUCE);
    cmd.mul_start = !mul_run && (state == ST_MUL_XX || state == ST_MUL_TX ||
                    state == ST_MUL_AX || state == ST_EXP_SQ ||
                    state == ST_EXP_MB || state == ST_CHECK);
    unique case (state)
      ST_MUL_TX: cmd.mul_op = OP_TX;
      ST_MUL_AX: cmd.mul_op = OP_AX;
      ST_EXP_SQ: cmd.mul_op = OP_ACC_ACC;
      ST_CHECK:  cmd.mul_op = OP_CHECK;
      ST_EXP_MB: cmd.mul_op = OP_ACC_BASE;
      default:   cmd.mul_op = OP_XX;
    endcase
    cmd.add_u     = (state == ST_ADD_U);
    cmd.add_b     = (state == ST_ADD_B);
    cmd.init_acc  = (state == ST_ADD_B);
    cmd.fix_y     = (state == ST_FIX);
    cmd.shift_out = out_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      word_count <= '0;
      ebit       <= 8'd255;
      mul_run    <= 1'b0;
      fail       <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc || out_acc) word_count <= word_count + CW'(1);
      if (cmd.mul_start) mul_run <= 1'b1;
      else if (sts.mul_done) mul_run <= 1'b0;
      if (state == ST_ADD_B) ebit <= 8'd255;
      else if (sts.mul_done && ((state == ST_EXP_SQ && !root_with_acc[ebit]) ||
                                state == ST_EXP_MB))
        ebit <= ebit - 8'd1;
      if (state == ST_FIX) fail <= !sts.root_ok;
    end
  end
endmodule

>>> src/p256_point_decompress_unit.sv
`timescale 1ns / 1ps
// P-256 point decompression, even-y form.
// Input channel: x_word with in_valid/in_stall; four transactions carry x,
// most significant word first.
// Output channel: y_word, last_word, status with out_valid/out_stall; four
// transactions follow each fourth input, most significant word first,
// last_word high on the fourth. status 1 means x has no root; y is zero then.
// Work: a single bit-serial modular multiplier does every multiply: three for
// x^3 + a*x, 256 squarings and 34 extra multiplies for the root, one check
// square. A shared modular adder forms t + u and t + b, and four one-step
// states (reduce, add u, add b, fix y) complete the sequence.
// A new x is taken only once all y words of the last one are taken; input,
// decompression and output run in turn. While busy or emitting, in_stall
// is high.
// When the receiver stalls, the current output word holds until taken.
// Reset (rst, synchronous) returns to collecting word zero of x; no memory
// sweep is needed.
module p256_point_decompress_unit
  import pdc_pkg::*;
#(
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] x_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] y_word,
  output logic        last_word,
  output logic        status
);
  cmd_t cmd;
  sts_t sts;
  logic [63:0] y_top;
  logic y_zero;

  pdc_control #(.NUM_WORDS(NUM_WORDS)) u_ctl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .last_word, .status, .y_zero, .sts, .cmd
  );

  pdc_datapath u_dp (
    .clk, .rst, .cmd, .x_word, .sts, .y_top
  );

  // Drop the root on failure.
  assign y_word = y_zero ? 64'd0 : y_top;
endmodule

>>> src/pdc_checker.sv
`timescale 1ns / 1ps
module pdc_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [63:0] y_word,
  input logic last_word,
  input logic status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(y_word)) else $error("hold");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> y_word == 64'd0) else $error("fail word");
  a_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word && !status |-> !y_word[0]) else $error("odd y");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("overlap");
endmodule

bind p256_point_decompress_unit pdc_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall,
  .y_word, .last_word, .status
);
